// ===== rtl/eru_pkg.sv =====
// ----------------------------------------------------------------------------
// eru_pkg
// Shared types and constants for the expert route usage table.
// ----------------------------------------------------------------------------
`default_nettype none

package eru_pkg;

  localparam int MAX_ROWS         = 64;
  localparam int MAX_EXPERTS      = 256;
  localparam int FACTOR_FRAC_BITS = 16;

  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_EXPERTS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_EXPERTS;
  localparam int CNT_W    = 32;
  localparam int FACTOR_W = FACTOR_FRAC_BITS + 1;
  localparam int PROD_W   = CNT_W + FACTOR_W;
  localparam int LCNT_W   = 6;
  localparam int ECNT_W   = 9;
  localparam int CMD_W    = 3;
  localparam int AMT_W    = 32;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE  = FACTOR_W'(1) << FACTOR_FRAC_BITS;
  localparam logic [PROD_W-1:0]   FACTOR_HALF = PROD_W'(1) << (FACTOR_FRAC_BITS - 1);

  localparam logic [LCNT_W-1:0]   LAYER_COUNT_RST  = LCNT_W'(63);
  localparam logic [ECNT_W-1:0]   EXPERT_COUNT_RST = ECNT_W'(256);
  localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST = FACTOR_ONE;

  localparam logic [CMD_W-1:0] CMD_COUNT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DROP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DECAY = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPERT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ROW_W-1:0] layer;
    logic [COL_W-1:0] expert;
    logic [AMT_W-1:0] amount;
    logic             last_id;
  } in_item_t;

  typedef struct packed {
    cnt_t read_value;
    logic accepted;
  } out_item_t;

  typedef struct packed {
    logic  valid;
    addr_t addr;
    logic  row_ok;
  } dec_req_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    cnt_t  data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ===== rtl/eru_ram.sv =====
// ----------------------------------------------------------------------------
// eru_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module eru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/eru_decay.sv =====
// ----------------------------------------------------------------------------
// eru_decay
// Decay datapath: aligns read data, multiplies by the factor, rounds and
// produces the write-back for each swept nonzero counter in a live row.
// ----------------------------------------------------------------------------
`default_nettype none

module eru_decay (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire eru_pkg::dec_req_t                req,
  input  wire eru_pkg::cnt_t                    rd_data,
  input  wire logic [eru_pkg::FACTOR_W-1:0]     factor,
  output eru_pkg::mem_wr_t                      wr,
  output logic                                  busy
);

  eru_pkg::dec_req_t              s1;
  logic                           s2_valid;
  eru_pkg::addr_t                 s2_addr;
  logic                           s2_upd;
  logic [eru_pkg::PROD_W-1:0]     s2_prod;
  logic [eru_pkg::PROD_W-1:0]     rounded;
  eru_pkg::cnt_t                  scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1.valid <= req.valid;
      s2_valid <= s1.valid;
    end
    s1.addr   <= req.addr;
    s1.row_ok <= req.row_ok;
    s2_addr   <= s1.addr;
    s2_upd    <= s1.row_ok && (rd_data != '0);
    s2_prod   <= eru_pkg::PROD_W'(rd_data) * eru_pkg::PROD_W'(factor);
  end

  assign rounded = s2_prod + eru_pkg::FACTOR_HALF;
  assign scaled  = rounded[eru_pkg::FACTOR_FRAC_BITS +: eru_pkg::CNT_W];

  // never decays a live counter to zero
  assign wr.en   = s2_valid && s2_upd;
  assign wr.addr = s2_addr;
  assign wr.data = (scaled == '0) ? eru_pkg::CNT_W'(1) : scaled;

  assign busy = s1.valid || s2_valid;

endmodule

`default_nettype wire

// ===== rtl/expert_route_usage_table.sv =====
// Flow: count, add and get pass through a read-modify-write state and then the hold state;
// drop row, a no-op decay, rejected and unknown commands go straight to the hold state;
// decay reads one counter per cycle into a 2-stage multiply pipe; clear writes every counter.
// One item is in progress at a time: in_ready stays low until its result is put on the output.
// Reset: a clearing pass writes all 16384 counters, one per cycle, with in_ready low.
// ----------------------------------------------------------------------------
// expert_route_usage_table
// Usage counter table in one synchronous RAM with per-row valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module expert_route_usage_table (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [eru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [eru_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire eru_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output eru_pkg::out_item_t                    out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_HOLD,
    ST_CLR,
    ST_DEC
  } state_t;

  state_t                             state;
  logic [eru_pkg::LCNT_W-1:0]         layer_count;
  logic [eru_pkg::ECNT_W-1:0]         expert_count;
  logic [eru_pkg::FACTOR_W-1:0]       decay_factor;
  logic [eru_pkg::MAX_ROWS-1:0]       row_valid;
  eru_pkg::addr_t                     clr_addr;
  logic                               clr_reply;
  logic [eru_pkg::ADDR_W:0]           ra;
  eru_pkg::addr_t                     rmw_addr;
  logic [eru_pkg::CMD_W-1:0]          rmw_cmd;
  logic [eru_pkg::AMT_W-1:0]          rmw_amount;
  eru_pkg::out_item_t                 res;

  logic                               take;
  logic                               admit;
  logic                               in_range;
  logic                               decay_noop;
  logic [eru_pkg::ROW_W-1:0]          rv_row;
  eru_pkg::addr_t                     rd_addr;
  eru_pkg::cnt_t                      rd_data;
  eru_pkg::dec_req_t                  dec_req;
  eru_pkg::mem_wr_t                   dec_wr;
  logic                               dec_busy;
  eru_pkg::mem_wr_t                   wr;

  assign in_ready   = (state == ST_IDLE);
  assign take       = in_valid && in_ready;
  assign rv_row     = (state == ST_DEC) ? ra[eru_pkg::ADDR_W-1:eru_pkg::COL_W] : in_data.layer;
  assign in_range   = (in_data.layer <= layer_count);
  assign admit      = in_range && row_valid[rv_row] &&
                      ({1'b0, in_data.expert} < expert_count);
  assign decay_noop = (decay_factor == '0) || (decay_factor >= eru_pkg::FACTOR_ONE);
  assign rd_addr    = (state == ST_DEC) ? ra[eru_pkg::ADDR_W-1:0]
                                        : {in_data.layer, in_data.expert};

  assign dec_req.valid  = (state == ST_DEC) && !ra[eru_pkg::ADDR_W];
  assign dec_req.addr   = ra[eru_pkg::ADDR_W-1:0];
  assign dec_req.row_ok = row_valid[rv_row];

  always_comb begin
    wr = '0;
    unique case (state)
      ST_RMW: begin
        wr.en   = (rmw_cmd != eru_pkg::CMD_GET);
        wr.addr = rmw_addr;
        wr.data = (rmw_cmd == eru_pkg::CMD_COUNT) ? rd_data + eru_pkg::CNT_W'(1)
                                                  : rd_data + rmw_amount;
      end
      ST_CLR: begin
        wr.en   = 1'b1;
        wr.addr = clr_addr;
        wr.data = '0;
      end
      ST_DEC: begin
        wr = dec_wr;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  eru_ram #(
    .WIDTH (eru_pkg::CNT_W),
    .DEPTH (eru_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  eru_decay u_decay (
    .clk     (clk),
    .rst     (rst),
    .req     (dec_req),
    .rd_data (rd_data),
    .factor  (decay_factor),
    .wr      (dec_wr),
    .busy    (dec_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLR;
      layer_count  <= eru_pkg::LAYER_COUNT_RST;
      expert_count <= eru_pkg::EXPERT_COUNT_RST;
      decay_factor <= eru_pkg::DECAY_FACTOR_RST;
      row_valid    <= '1;
      clr_addr     <= '0;
      clr_reply    <= 1'b0;
      ra           <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          eru_pkg::REG_LAYER_COUNT:  layer_count  <= cfg_data[eru_pkg::LCNT_W-1:0];
          eru_pkg::REG_EXPERT_COUNT: expert_count <= cfg_data[eru_pkg::ECNT_W-1:0];
          eru_pkg::REG_DECAY_FACTOR: decay_factor <= cfg_data[eru_pkg::FACTOR_W-1:0];
          default: ;
        endcase
      end

      if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (take) begin
            rmw_addr   <= {in_data.layer, in_data.expert};
            rmw_cmd    <= in_data.command;
            rmw_amount <= in_data.amount;
            res        <= '0;
            state      <= ST_HOLD;
            unique case (in_data.command)
              eru_pkg::CMD_COUNT, eru_pkg::CMD_ADD, eru_pkg::CMD_GET: begin
                if (admit) begin
                  state <= ST_RMW;
                end
              end
              eru_pkg::CMD_DROP: begin
                if (in_range) begin
                  row_valid[in_data.layer] <= 1'b0;
                  res.accepted             <= 1'b1;
                end
              end
              eru_pkg::CMD_DECAY: begin
                res.accepted <= 1'b1;
                if (!decay_noop) begin
                  ra    <= '0;
                  state <= ST_DEC;
                end
              end
              eru_pkg::CMD_CLEAR: begin
                row_valid    <= '1;
                clr_addr     <= '0;
                clr_reply    <= 1'b1;
                res.accepted <= 1'b1;
                state        <= ST_CLR;
              end
              default: ;
            endcase
          end
        end
        ST_RMW: begin
          res.accepted   <= 1'b1;
          res.read_value <= (rmw_cmd == eru_pkg::CMD_GET) ? rd_data : '0;
          state          <= ST_HOLD;
        end
        ST_CLR: begin
          clr_addr <= clr_addr + eru_pkg::ADDR_W'(1);
          if (clr_addr == eru_pkg::ADDR_W'(eru_pkg::DEPTH - 1)) begin
            state <= clr_reply ? ST_HOLD : ST_IDLE;
          end
        end
        ST_DEC: begin
          if (!ra[eru_pkg::ADDR_W]) begin
            ra <= ra + (eru_pkg::ADDR_W + 1)'(1);
          end else if (!dec_busy) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eru_checker.sv =====
// ----------------------------------------------------------------------------
// eru_checker
// Port-level checks for the expert route usage table.
// ----------------------------------------------------------------------------
`default_nettype none

module eru_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire eru_pkg::in_item_t                in_data,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire eru_pkg::out_item_t               out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

  a_value_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.read_value != '0) |-> out_data.accepted)
    else $error("read value on a rejected item");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_clear_ok: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.command == eru_pkg::CMD_CLEAR) |=> !out_valid ||
    $past(out_valid && !out_ready))
    else $error("clear result delivered too early");

endmodule

bind expert_route_usage_table eru_checker u_eru_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the expert route usage table. A clocked driver
// feeds items from a queue and a software copy of the counter store predicts
// each result. A clocked monitor checks every result in order. The run goes
// through several limit and decay settings, most with random stalls on both sides.
// ----------------------------------------------------------------------------

module tb;
  import eru_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  // software copy of the store and its limits
  cnt_t usage_model [DEPTH];
  logic [MAX_ROWS-1:0] row_live;
  logic [LCNT_W-1:0] lim_layer;
  logic [ECNT_W-1:0] lim_expert;
  logic [FACTOR_W-1:0] decay_mul;

  in_item_t pending_commands [$];
  out_item_t expected_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned sent_total = 0;
  int unsigned taken_total = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned n_admitted = 0;
  int unsigned n_refused = 0;
  int unsigned n_drops = 0;
  int unsigned n_decays = 0;
  int unsigned n_clears = 0;

  expert_route_usage_table DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic void wipe_model();
    int i;
    for (i = 0; i < DEPTH; i++) usage_model[i] = '0;
    row_live = '1;
  endfunction

  function automatic out_item_t route_table_update(in_item_t it);
    out_item_t res;
    int i;
    logic layer_ok;
    logic admit;
    bit [63:0] scaled;
    res = '0;
    layer_ok = (it.layer <= lim_layer);
    admit = layer_ok && row_live[it.layer] && (it.expert < lim_expert);
    i = int'({it.layer, it.expert});
    case (it.command)
      CMD_COUNT, CMD_ADD, CMD_GET: begin
        if (admit) begin
          res.accepted = 1'b1;
          n_admitted++;
          if (it.command == CMD_COUNT) usage_model[i] = usage_model[i] + 32'd1;
          else if (it.command == CMD_ADD) usage_model[i] = usage_model[i] + it.amount;
          else res.read_value = usage_model[i];
        end else begin
          n_refused++;
        end
      end
      CMD_DROP: begin
        if (layer_ok) begin
          row_live[it.layer] = 1'b0;
          res.accepted = 1'b1;
          n_drops++;
        end
      end
      CMD_DECAY: begin
        res.accepted = 1'b1;
        n_decays++;
        if (decay_mul != 0 && decay_mul < FACTOR_ONE) begin
          for (i = 0; i < DEPTH; i++) begin
            if (row_live[i / MAX_EXPERTS] && usage_model[i] != 0) begin
              scaled = (64'(usage_model[i]) * 64'(decay_mul) + 64'(FACTOR_HALF))
                       >> FACTOR_FRAC_BITS;
              usage_model[i] = (scaled == 0) ? 32'd1 : scaled[31:0];
            end
          end
        end
      end
      CMD_CLEAR: begin
        wipe_model();
        res.accepted = 1'b1;
        n_clears++;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(route_table_update(in_data));
        taken_total++;
      end
      if (!in_valid || in_ready) begin
        if (pending_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_commands.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (error_count < 10)
            $display("unexpected result: read_value %h accepted %0b",
                     out_data.read_value, out_data.accepted);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (want.read_value !== out_data.read_value ||
              want.accepted !== out_data.accepted) begin
            if (error_count < 10)
              $display("mismatch: read_value exp %h got %h, accepted exp %0b got %0b",
                       want.read_value, out_data.read_value,
                       want.accepted, out_data.accepted);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_item(logic [CMD_W-1:0] cmd, int unsigned row, int unsigned col,
                           logic [AMT_W-1:0] amount, logic last);
    in_item_t it;
    it.command = cmd;
    it.layer = ROW_W'(row);
    it.expert = COL_W'(col);
    it.amount = amount;
    it.last_id = last;
    pending_commands.push_back(it);
    sent_total++;
  endtask

  task automatic drain();
    while (taken_total != sent_total || expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic configure(int unsigned lc, int unsigned ec, int unsigned df,
                           int unsigned send_pct, int unsigned recv_pct);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LAYER_COUNT;
    cfg_data <= CFG_W'(lc);
    @(posedge clk);
    cfg_index <= REG_EXPERT_COUNT;
    cfg_data <= CFG_W'(ec);
    @(posedge clk);
    cfg_index <= REG_DECAY_FACTOR;
    cfg_data <= CFG_W'(df);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    lim_layer = LCNT_W'(lc);
    lim_expert = ECNT_W'(ec);
    decay_mul = FACTOR_W'(df);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic queue_random(int n);
    in_item_t it;
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 999);
      if (pick < 380) it.command = CMD_COUNT;
      else if (pick < 540) it.command = CMD_ADD;
      else if (pick < 920) it.command = CMD_GET;
      else if (pick < 930) it.command = CMD_DROP;
      else if (pick < 939) it.command = CMD_DECAY;
      else if (pick < 944) it.command = CMD_CLEAR;
      else if (pick < 974) it.command = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      else it.command = CMD_COUNT;
      // mostly a few hot counters so values build up, plus the limit edges
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 4))
          0: it.layer = lim_layer;
          1: it.layer = lim_layer + 6'd1;
          default: it.layer = ROW_W'($urandom_range(0, lim_layer < 3 ? lim_layer : 3));
        endcase
        case ($urandom_range(0, 4))
          0: it.expert = COL_W'(lim_expert - 1);
          1: it.expert = lim_expert[COL_W-1:0];
          default: it.expert = COL_W'($urandom_range(0, lim_expert < 8 ? lim_expert - 1 : 7));
        endcase
      end else begin
        it.layer = ROW_W'($urandom_range(0, 63));
        it.expert = COL_W'($urandom_range(0, 255));
      end
      if (it.command == CMD_DROP && $urandom_range(0, 1))
        it.layer = ROW_W'($urandom_range(0, 63));
      it.amount = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 15);
      it.last_id = 1'($urandom_range(0, 1));
      pending_commands.push_back(it);
      sent_total++;
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(negedge clk);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int k;
    int unsigned lc_set [7] = '{0, 31, 63, 7, 63, 15, 63};
    int unsigned ec_set [7] = '{1, 128, 256, 200, 256, 17, 255};
    int unsigned df_set [7] = '{1, 65535, 0, 40000, 65536, 3, 52000};
    wipe_model();
    lim_layer = LAYER_COUNT_RST;
    lim_expert = EXPERT_COUNT_RST;
    decay_mul = DECAY_FACTOR_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // block clears its store after reset
    @(negedge clk);
    while (!in_ready) @(negedge clk);

    configure(63, 256, 65536, 35, 67);
    push_item(CMD_COUNT, 0, 0, 32'h0, 1'b0);
    push_item(CMD_COUNT, 0, 0, 32'hFFFF_FFFF, 1'b1);
    push_item(CMD_COUNT, 63, 255, 32'h0, 1'b0);
    push_item(CMD_ADD, 63, 255, 32'hFFFF_FFFF, 1'b1);
    push_item(CMD_GET, 63, 255, 32'h0, 1'b0);
    push_item(CMD_ADD, 0, 0, 32'hFFFF_FFFF, 1'b0);
    push_item(CMD_GET, 0, 0, 32'h0, 1'b1);
    push_item(CMD_ADD, 5, 17, 32'hA5A5_A5A5, 1'b0);
    push_item(CMD_GET, 5, 17, 32'h0, 1'b0);
    push_item(CMD_DECAY, 0, 0, 32'h0, 1'b0);
    push_item(CMD_GET, 5, 17, 32'h0, 1'b0);
    push_item(CMD_DROP, 5, 0, 32'h0, 1'b0);
    push_item(CMD_GET, 5, 17, 32'h0, 1'b0);
    push_item(CMD_COUNT, 5, 17, 32'h0, 1'b1);
    push_item(CMD_DROP, 5, 0, 32'h0, 1'b0);
    push_item(CMD_SPARE_A, 1, 1, 32'h5A5A_5A5A, 1'b0);
    push_item(CMD_SPARE_B, 1, 1, 32'h0000_0001, 1'b1);
    push_item(CMD_GET, 0, 0, 32'h0, 1'b0);
    push_item(CMD_CLEAR, 0, 0, 32'h0, 1'b0);
    push_item(CMD_GET, 0, 0, 32'h0, 1'b0);
    push_item(CMD_GET, 5, 17, 32'h0, 1'b0);
    push_item(CMD_ADD, 1, 128, 32'h0001_0001, 1'b0);
    push_item(CMD_COUNT, 62, 0, 32'h0, 1'b1);
    queue_random(180);

    // half factor: rounding and the floor of one
    configure(63, 256, 32768, 35, 67);
    push_item(CMD_DECAY, 0, 0, 32'h0, 1'b0);
    push_item(CMD_GET, 1, 128, 32'h0, 1'b0);
    push_item(CMD_GET, 62, 0, 32'h0, 1'b1);
    queue_random(200);

    for (k = 0; k < 7; k++) begin
      if (k == 0) configure(lc_set[k], ec_set[k], df_set[k], 35, 67);
      else if (k < 4) configure(lc_set[k], ec_set[k], df_set[k], 67, 35);
      else configure(lc_set[k], ec_set[k], df_set[k], 0, 0);
      queue_random(205);
    end

    drain();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      error_count++;
    end
    $display("covered %0d items: %0d counter updates or reads admitted, %0d refused, %0d row drops",
             taken_total, n_admitted, n_refused, n_drops);
    $display("%0d decay walks and %0d clears over 9 register settings, %0d errors",
             n_decays, n_clears, error_count);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/eru_pkg.sv
rtl/eru_ram.sv
rtl/eru_decay.sv
rtl/expert_route_usage_table.sv
rtl/eru_checker.sv
test/tb.sv
